// ----- rtl/register_free_pool_and_var_map_unit_macros.svh -----
// assertion macros for the register free pool and variable map unit
// used by the top level; expects signals named clock and reset in scope
`ifndef REGISTER_FREE_POOL_AND_VAR_MAP_UNIT_MACROS_SVH
`define REGISTER_FREE_POOL_AND_VAR_MAP_UNIT_MACROS_SVH

// property that must hold at every edge out of reset
`define RFP_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define RFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rfp_pkg.sv -----
// shared types and constants for the register free pool and variable map unit
// no dependencies
`timescale 1ns / 1ps

package rfp_pkg;

   // field widths
   localparam int CMD_W  = 3;
   localparam int VAR_W  = 8;
   localparam int REG_W  = 6;
   localparam int POOL_W = 64;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RETURN     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INVALIDATE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TRANSFER   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ESTABLISH  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_START      = 3'd6;

   // write port of the map table
   typedef struct packed {
      logic             en;
      logic [VAR_W-1:0] addr;
      logic [REG_W-1:0] data;
   } map_wr_type;

endpackage

// ----- rtl/register_free_pool_and_var_map_unit.sv -----
// Register free pool and variable map unit: keeps a 64-bit free-register bitmap and a
// variable-to-register table with per-entry valid bits, and runs one command per
// transaction (allocate, return, lookup, invalidate, transfer, establish, start).
// A new request is taken every cycle while responses drain, and each one returns exactly
// one response. The table is read at the edge that takes the request into the request
// register; the command logic then updates pool, valid bits and table and loads the
// response register once the response output is free, and the response is presented
// from that register. A stalled response holds the request register and then the
// input.
// Valid bits live in flops, so start clears the whole map at once; the table
// itself is not cleared. Depends on rfp_pkg, rfp_pick, rfp_map_ram and the macros header.
`timescale 1ns / 1ps
`include "register_free_pool_and_var_map_unit_macros.svh"

module register_free_pool_and_var_map_unit
   import rfp_pkg::*;
#(
   parameter int VAR_COUNT = 256
)
(
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [POOL_W-1:0] csr_available_registers,
   // request
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [VAR_W-1:0]  req_variable_id,
   input  logic [REG_W-1:0]  req_reg_index,
   input  logic [POOL_W-1:0] req_reg_mask,
   // response
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [REG_W-1:0]  rsp_reg_out,
   output logic              rsp_reg_valid,
   output logic              rsp_needs_move
);

   // only ids reachable by the 8-bit variable field get an entry
   localparam int ENTRIES = (VAR_COUNT < (1 << VAR_W)) ? VAR_COUNT : (1 << VAR_W);
   localparam int ADDR_W  = $clog2(ENTRIES);

   logic [POOL_W-1:0]  avail_ff;
   logic [POOL_W-1:0]  free_pool_ff, free_pool_in;
   logic [ENTRIES-1:0] map_valid_ff, map_valid_in;

   logic               s1_valid_ff;
   logic [CMD_W-1:0]   s1_cmd_ff;
   logic [VAR_W-1:0]   s1_var_ff;
   logic [REG_W-1:0]   s1_idx_ff;
   logic [POOL_W-1:0]  s1_mask_ff;

   logic               rsp_valid_ff;
   logic [REG_W-1:0]   rsp_reg_out_ff, rsp_reg_out_in;
   logic               rsp_reg_valid_ff, rsp_reg_valid_in;
   logic               rsp_needs_move_ff, rsp_needs_move_in;

   logic               out_free, fire, req_fire;
   logic               in_range, mapped;
   logic [ADDR_W-1:0]  s1_addr;
   logic [REG_W-1:0]   map_reg;
   logic               pick_found;
   logic [REG_W-1:0]   pick_idx;
   map_wr_type         map_wr;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         avail_ff <= csr_available_registers;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= req_cmd;
         s1_var_ff  <= req_variable_id;
         s1_idx_ff  <= req_reg_index;
         s1_mask_ff <= req_reg_mask;
      end
   end

   // map table, read as the request is taken
   rfp_map_ram #(
      .DEPTH  (ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_map_ram (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (req_variable_id),
      .wr      (map_wr),
      .rd_data (map_reg)
   );

   // highest free register allowed by the mask
   rfp_pick u_pick (
      .cand  (free_pool_ff & s1_mask_ff),
      .found (pick_found),
      .idx   (pick_idx)
   );

   // variable lookup
   assign s1_addr  = s1_var_ff[ADDR_W-1:0];
   assign in_range = 32'(s1_var_ff) < 32'(ENTRIES);
   assign mapped   = in_range && map_valid_ff[s1_addr];

   // command execution
   always_comb begin
      free_pool_in      = free_pool_ff;
      map_valid_in      = map_valid_ff;
      map_wr.en         = 1'b0;
      map_wr.addr       = s1_var_ff;
      map_wr.data       = s1_idx_ff;
      rsp_reg_out_in    = '0;
      rsp_reg_valid_in  = 1'b0;
      rsp_needs_move_in = 1'b0;
      if (fire) begin
         case (s1_cmd_ff)
            CMD_ALLOC: begin
               if (pick_found) begin
                  free_pool_in     = free_pool_ff & ~(POOL_W'(1) << pick_idx);
                  rsp_reg_out_in   = pick_idx;
                  rsp_reg_valid_in = 1'b1;
               end
            end
            CMD_RETURN: begin
               free_pool_in = free_pool_ff | (POOL_W'(1) << s1_idx_ff);
            end
            CMD_LOOKUP: begin
               if (mapped) begin
                  rsp_reg_out_in    = map_reg;
                  rsp_reg_valid_in  = 1'b1;
                  rsp_needs_move_in = !s1_mask_ff[map_reg];
               end else begin
                  rsp_needs_move_in = 1'b1;
               end
            end
            CMD_INVALIDATE: begin
               if (mapped) begin
                  free_pool_in          = free_pool_ff | (POOL_W'(1) << map_reg);
                  map_valid_in[s1_addr] = 1'b0;
               end
            end
            CMD_TRANSFER: begin
               if (mapped) begin
                  free_pool_in = free_pool_ff | (POOL_W'(1) << map_reg);
                  map_wr.en    = 1'b1;
               end
            end
            CMD_ESTABLISH: begin
               if (in_range) begin
                  map_wr.en             = 1'b1;
                  map_valid_in[s1_addr] = 1'b1;
               end
            end
            CMD_START: begin
               free_pool_in = avail_ff;
               map_valid_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // pool and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         free_pool_ff <= '1;
         map_valid_ff <= '0;
      end else begin
         free_pool_ff <= free_pool_in;
         map_valid_ff <= map_valid_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_reg_out_ff    <= rsp_reg_out_in;
         rsp_reg_valid_ff  <= rsp_reg_valid_in;
         rsp_needs_move_ff <= rsp_needs_move_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_out    = rsp_reg_out_ff;
   assign rsp_reg_valid  = rsp_reg_valid_ff;
   assign rsp_needs_move = rsp_needs_move_ff;

   // checks
   `RFP_ASSERT_NEXT(a_alloc_clears, fire && (s1_cmd_ff == CMD_ALLOC) && pick_found, !free_pool_ff[$past(pick_idx)], "allocated register still free")
   `RFP_ASSERT_NEXT(a_start_loads, fire && (s1_cmd_ff == CMD_START), (free_pool_ff == $past(avail_ff)) && (map_valid_ff == '0), "start did not load pool or clear map")
   `RFP_ASSERT_NEXT(a_req_held, s1_valid_ff && !fire, s1_valid_ff, "pending request dropped")
   `RFP_ASSERT_ALWAYS(a_invalid_zero, !rsp_valid_ff || rsp_reg_valid_ff || (rsp_reg_out_ff == '0), "invalid response carries a register")

endmodule

// ----- rtl/rfp_pick.sv -----
// highest set bit finder over the 64-bit candidate register bitmap
// depends on rfp_pkg
`timescale 1ns / 1ps

module rfp_pick
   import rfp_pkg::*;
(
   input  logic [POOL_W-1:0] cand,
   output logic              found,
   output logic [REG_W-1:0]  idx
);

   logic [31:0] v32;
   logic [15:0] v16;
   logic [7:0]  v8;
   logic [3:0]  v4;
   logic [1:0]  v2;
   logic        hi32, hi16, hi8, hi4, hi2, hi1;

   // binary search for the top set bit, one halving per level
   always_comb begin
      hi32 = |cand[63:32];
      v32  = hi32 ? cand[63:32] : cand[31:0];
      hi16 = |v32[31:16];
      v16  = hi16 ? v32[31:16] : v32[15:0];
      hi8  = |v16[15:8];
      v8   = hi8 ? v16[15:8] : v16[7:0];
      hi4  = |v8[7:4];
      v4   = hi4 ? v8[7:4] : v8[3:0];
      hi2  = |v4[3:2];
      v2   = hi2 ? v4[3:2] : v4[1:0];
      hi1  = v2[1];
   end

   assign found = |cand;
   assign idx   = {hi32, hi16, hi8, hi4, hi2, hi1};

endmodule

// ----- rtl/rfp_map_ram.sv -----
// variable-to-register map table: one write port, one registered read port
// depends on rfp_pkg; a read of the address written in the same cycle gets the new data
`timescale 1ns / 1ps

module rfp_map_ram
   import rfp_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
)
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic [VAR_W-1:0] rd_addr,
   input  map_wr_type       wr,
   output logic [REG_W-1:0] rd_data
);

   logic [REG_W-1:0] mem [DEPTH];
   logic [REG_W-1:0] rd_data_ff;

   // table write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[ADDR_W-1:0]] <= wr.data;
      end
   end

   // registered read with bypass of a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr[ADDR_W-1:0]];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule
